>>> sv/rci_pkg.sv
// ----------------------------------------------------------------------------
// rci_pkg: shared types and helpers of the ray/cube intersection block
// Payload structs, per-face pipeline records and fixed point saturation.
// ----------------------------------------------------------------------------
package rci_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int NUM_FACES       = 6;
	localparam int QBITS           = 33;
	localparam logic [30:0] HALF_SIZE_RESET = 31'd49152;

	typedef enum logic [2:0] {
		FACE_NX,
		FACE_NY,
		FACE_NZ,
		FACE_PX,
		FACE_PY,
		FACE_PZ
	} face_t;

	// One ray as it enters the block.
	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic signed [31:0] t_min;
		logic signed [31:0] t_limit;
	} ray_in_t;

	// One result as it leaves the block.
	typedef struct packed {
		logic               hit;
		logic signed [31:0] nearest_t;
		logic [2:0]         face;
	} ray_out_t;

	// Division state of one face while the quotient is built bit by bit.
	typedef struct packed {
		logic        skip;
		logic        neg;
		logic        ovf;
		logic [32:0] num_mag;
		logic [31:0] den_mag;
		logic [32:0] rem;
		logic [32:0] quo;
	} div_lane_t;

	typedef struct packed {
		ray_in_t                     ray;
		div_lane_t [NUM_FACES-1:0]   lane;
	} div_stage_t;

	// Candidate face after its distance and hit point are known.
	typedef struct packed {
		logic               skip;
		logic               in_box;
		logic signed [31:0] t;
	} cand_t;

	typedef struct packed {
		cand_t [NUM_FACES-1:0] cand;
		logic signed [31:0]    t_min;
		logic signed [31:0]    nearest;
		logic                  hit;
		face_t                 face;
	} sel_stage_t;

	// Origin component on one axis.
	function automatic logic signed [31:0] ray_org(input ray_in_t r, input int axis);
		logic signed [31:0] v;
		case (axis)
			0: v = r.origin_x;
			1: v = r.origin_y;
			default: v = r.origin_z;
		endcase
		return v;
	endfunction

	// Direction component on one axis.
	function automatic logic signed [31:0] ray_dir(input ray_in_t r, input int axis);
		logic signed [31:0] v;
		case (axis)
			0: v = r.dir_x;
			1: v = r.dir_y;
			default: v = r.dir_z;
		endcase
		return v;
	endfunction

	// Clamp a wide signed value to the 32-bit signed range.
	function automatic logic signed [31:0] sat_to_32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> sv/rci_div_cell.sv
// ----------------------------------------------------------------------------
// rci_div_cell: one quotient bit of the face distance division
// Shifts one dividend bit into the remainder of each of the six faces,
// subtracts the divisor where it fits and registers the result.
// ----------------------------------------------------------------------------
module rci_div_cell #(
	parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF,
	parameter int BIT       = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  rci_pkg::div_stage_t up,
	output logic                dn_valid,
	input  logic                dn_ready,
	output rci_pkg::div_stage_t dn
);
	import rci_pkg::*;

	logic       valid_q;
	div_stage_t data_q;
	div_stage_t nxt;

	// Restoring division step for every face lane.
	for (genvar f = 0; f < NUM_FACES; f++) begin : g_lane
		logic        dbit;
		logic [32:0] trial;
		logic        fits;

		if (BIT >= FRAC_BITS) begin : g_num
			assign dbit = up.lane[f].num_mag[BIT-FRAC_BITS];
		end else begin : g_zero
			assign dbit = 1'b0;
		end

		assign trial = {up.lane[f].rem[31:0], dbit};
		assign fits  = trial >= {1'b0, up.lane[f].den_mag};

		always_comb begin
			nxt.lane[f]     = up.lane[f];
			nxt.lane[f].rem = fits ? (trial - {1'b0, up.lane[f].den_mag}) : trial;
			nxt.lane[f].quo = {up.lane[f].quo[31:0], fits};
		end
	end
	assign nxt.ray = up.ray;

	// Stage register; a bubble may be filled while the next stage stalls.
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn       = data_q;

endmodule

>>> sv/rci_hitpt.sv
// ----------------------------------------------------------------------------
// rci_hitpt: face distance saturation and hit point bounds test
// Three stages: saturate the quotient, form the products on the two other
// axes, then scale, add the origin and compare against the cube bounds.
// ----------------------------------------------------------------------------
module rci_hitpt #(
	parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [30:0]         half_size,
	input  logic                up_valid,
	output logic                up_ready,
	input  rci_pkg::div_stage_t up,
	output logic                dn_valid,
	input  logic                dn_ready,
	output rci_pkg::sel_stage_t dn
);
	import rci_pkg::*;

	localparam logic signed [63:0] ROUND = (64'sd1 <<< FRAC_BITS) - 64'sd1;

	logic valid_s1, valid_s2, valid_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	ray_in_t               ray_s1, ray_s2, ray_s3;
	cand_t [NUM_FACES-1:0] cand_s1, cand_s2, cand_s3;
	logic signed [63:0]    prod_s2 [NUM_FACES][2];

	cand_t [NUM_FACES-1:0] cand_c1, cand_c3;
	logic signed [63:0]    prod_c2 [NUM_FACES][2];

	assign rdy_s3   = !valid_s3 || dn_ready;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
		localparam int A  = f % 3;
		localparam int K1 = (A + 1) % 3;
		localparam int K2 = (A + 2) % 3;

		// Saturate the quotient magnitude with its sign.
		always_comb begin
			cand_c1[f].skip   = up.lane[f].skip;
			cand_c1[f].in_box = 1'b0;
			if (up.lane[f].neg) begin
				if (up.lane[f].ovf || up.lane[f].quo > 33'h0_8000_0000) begin
					cand_c1[f].t = 32'sh8000_0000;
				end else begin
					cand_c1[f].t = 32'(-up.lane[f].quo);
				end
			end else begin
				if (up.lane[f].ovf || up.lane[f].quo > 33'h0_7FFF_FFFF) begin
					cand_c1[f].t = 32'sh7FFF_FFFF;
				end else begin
					cand_c1[f].t = up.lane[f].quo[31:0];
				end
			end
		end

		// Distance times direction on the two other axes.
		assign prod_c2[f][0] = 64'(cand_s1[f].t) * 64'(ray_dir(ray_s1, K1));
		assign prod_c2[f][1] = 64'(cand_s1[f].t) * 64'(ray_dir(ray_s1, K2));

		// Scale back, add the origin and test against the closed bounds.
		always_comb begin
			logic signed [63:0] scaled [2];
			logic signed [31:0] coord  [2];
			logic signed [32:0] hs;
			logic               ok;
			hs = $signed({2'b00, half_size});
			ok = 1'b1;
			for (int k = 0; k < 2; k++) begin
				if (prod_s2[f][k][63]) begin
					scaled[k] = (prod_s2[f][k] + ROUND) >>> FRAC_BITS;
				end else begin
					scaled[k] = prod_s2[f][k] >>> FRAC_BITS;
				end
				coord[k] = sat_to_32(64'(sat_to_32(scaled[k]))
					+ 64'(ray_org(ray_s2, (k == 0) ? K1 : K2)));
				if (33'(coord[k]) < -hs || 33'(coord[k]) > hs) begin
					ok = 1'b0;
				end
			end
			cand_c3[f]        = cand_s2[f];
			cand_c3[f].in_box = ok;
		end
	end

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= up_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
		end
	end

	// Payload registers of the three stages.
	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			ray_s1  <= up.ray;
			cand_s1 <= cand_c1;
		end
		if (rdy_s2 && valid_s1) begin
			ray_s2  <= ray_s1;
			cand_s2 <= cand_s1;
			prod_s2 <= prod_c2;
		end
		if (rdy_s3 && valid_s2) begin
			ray_s3  <= ray_s2;
			cand_s3 <= cand_c3;
		end
	end

	assign dn_valid   = valid_s3;
	assign dn.cand    = cand_s3;
	assign dn.t_min   = ray_s3.t_min;
	assign dn.nearest = ray_s3.t_limit;
	assign dn.hit     = 1'b0;
	assign dn.face    = FACE_NX;

endmodule

>>> sv/rci_select_cell.sv
// ----------------------------------------------------------------------------
// rci_select_cell: nearest face selection for one face
// Accepts its face when the distance lies in the open window and the hit
// point is inside the cube, then hands the running nearest hit onward.
// ----------------------------------------------------------------------------
module rci_select_cell #(
	parameter int FACE = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  rci_pkg::sel_stage_t up,
	output logic                dn_valid,
	input  logic                dn_ready,
	output rci_pkg::sel_stage_t dn
);
	import rci_pkg::*;

	logic       valid_q;
	sel_stage_t data_q;
	sel_stage_t nxt;
	logic       take;

	// Strict compares keep the earlier face on equal distance.
	assign take = !up.cand[FACE].skip && up.cand[FACE].in_box
		&& (up.cand[FACE].t > up.t_min) && (up.cand[FACE].t < up.nearest);

	always_comb begin
		nxt = up;
		if (take) begin
			nxt.nearest = up.cand[FACE].t;
			nxt.hit     = 1'b1;
			nxt.face    = face_t'(3'(FACE));
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn       = data_q;

endmodule

>>> sv/ray_cube_intersection_top.sv
// ----------------------------------------------------------------------------
// ray_cube_intersection_top: ray versus origin-centered cube test
// Divider chain of 33 quotient-bit cells, a hit point stage and six face
// selection cells, all streaming one ray per cycle while res_ready holds.
// ----------------------------------------------------------------------------
// Path from an accepted ray to its result: 33 divider cells, 3 hit point
// stages, 6 selection cells; throughput is one ray per cycle while res_ready
// holds, set by the one-bit-per-cell division chain that every stage advances.
// Each stage fills a bubble while later stages stall.
// Reset clears all valid bits and loads half_size with 0.75.
module ray_cube_intersection_top #(
	parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ray_valid,
	output logic             ray_ready,
	input  rci_pkg::ray_in_t ray,
	output logic             res_valid,
	input  logic             res_ready,
	output rci_pkg::ray_out_t res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [30:0]      cfg_data
);
	import rci_pkg::*;

	localparam int NCELL = QBITS;

	logic [30:0] half_size_q;

	div_stage_t div_bus   [NCELL+1];
	logic       div_valid [NCELL+1];
	logic       div_ready [NCELL+1];

	sel_stage_t sel_bus   [NUM_FACES+1];
	logic       sel_valid [NUM_FACES+1];
	logic       sel_ready [NUM_FACES+1];

	// Configuration register; every transaction is taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_size_q <= HALF_SIZE_RESET;
		end else if (cfg_valid) begin
			half_size_q <= cfg_data;
		end
	end

	// Numerator and denominator magnitudes and the quotient sign per face.
	for (genvar f = 0; f < NUM_FACES; f++) begin : g_pre
		localparam int A = f % 3;
		localparam bit NEG_FACE = (f < 3);

		logic signed [33:0] num;
		logic signed [32:0] den;
		logic [32:0]        nmag;
		logic [32:0]        dmag;
		logic [32:0]        rem0;

		assign num  = NEG_FACE ? ($signed({3'b000, half_size_q}) + 34'(ray_org(ray, A)))
			: ($signed({3'b000, half_size_q}) - 34'(ray_org(ray, A)));
		assign den  = NEG_FACE ? -33'(ray_dir(ray, A)) : 33'(ray_dir(ray, A));
		assign nmag = num[33] ? 33'(-num) : num[32:0];
		assign dmag = den[32] ? 33'(-den) : den;
		assign rem0 = nmag >> (QBITS - FRAC_BITS);

		always_comb begin
			div_bus[0].lane[f].skip    = (den == 33'sd0);
			div_bus[0].lane[f].neg     = num[33] ^ den[32];
			div_bus[0].lane[f].num_mag = nmag;
			div_bus[0].lane[f].den_mag = dmag[31:0];
			div_bus[0].lane[f].ovf     = rem0 >= dmag;
			div_bus[0].lane[f].rem     = rem0;
			div_bus[0].lane[f].quo     = '0;
		end
	end

	assign div_bus[0].ray = ray;
	assign div_valid[0]   = ray_valid;
	assign ray_ready      = div_ready[0];

	// Divider chain, most significant quotient bit first.
	for (genvar i = 0; i < NCELL; i++) begin : g_div
		rci_div_cell #(
			.FRAC_BITS(FRAC_BITS),
			.BIT      (NCELL - 1 - i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(div_valid[i]),
			.up_ready(div_ready[i]),
			.up      (div_bus[i]),
			.dn_valid(div_valid[i+1]),
			.dn_ready(div_ready[i+1]),
			.dn      (div_bus[i+1])
		);
	end

	// Distance saturation and bounds test.
	rci_hitpt #(
		.FRAC_BITS(FRAC_BITS)
	) u_hitpt (
		.clk      (clk),
		.arst_n   (arst_n),
		.half_size(half_size_q),
		.up_valid (div_valid[NCELL]),
		.up_ready (div_ready[NCELL]),
		.up       (div_bus[NCELL]),
		.dn_valid (sel_valid[0]),
		.dn_ready (sel_ready[0]),
		.dn       (sel_bus[0])
	);

	// Face selection chain in face order; the last cell is the output register.
	for (genvar f = 0; f < NUM_FACES; f++) begin : g_sel
		rci_select_cell #(
			.FACE(f)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(sel_valid[f]),
			.up_ready(sel_ready[f]),
			.up      (sel_bus[f]),
			.dn_valid(sel_valid[f+1]),
			.dn_ready(sel_ready[f+1]),
			.dn      (sel_bus[f+1])
		);
	end

	assign res_valid           = sel_valid[NUM_FACES];
	assign sel_ready[NUM_FACES] = res_ready;
	assign res.hit             = sel_bus[NUM_FACES].hit;
	assign res.nearest_t       = sel_bus[NUM_FACES].nearest;
	assign res.face            = sel_bus[NUM_FACES].face;

	// A missed ray reports the first face code.
	a_miss_face: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.hit) |-> (res.face == FACE_NX))
		else $error("result without hit carries a nonzero face");

	// A reported face is one of the six cube faces.
	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.face <= FACE_PZ))
		else $error("result face code out of range");

	// A stalled result keeps its fields until the transaction completes.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("stalled result changed");

	// An empty first stage never holds off the input.
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		(!div_valid[1]) |-> ray_ready)
		else $error("input stalled with an empty first stage");

endmodule
